FILE: rtl/qfs_pkg.sv
// shared types, constants and helpers of the quoted field splitter
package qfs_pkg;

  localparam logic [8:0] WS_SELECT   = 9'd256;
  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] ESCAPE_BYTE = 8'h5C;

  localparam logic CFG_SEPARATOR  = 1'b0;
  localparam logic CFG_MAX_SPLITS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_BYTE,
    ST_OVF,
    ST_FIN,
    ST_END
  } state_t;

  typedef struct packed {
    logic       flush;
    logic       byte_out;
    logic       ovf;
    logic       fin;
    logic       end_out;
    logic       end_disc;
    logic [7:0] byte_val;
  } plan_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // first result kind of the plan that comes after cur
  function automatic state_t stage_after(input plan_t p, input state_t cur);
    state_t r;
    r = ST_IDLE;
    if (p.end_out && (cur < ST_END)) r = ST_END;
    if (p.fin && (cur < ST_FIN)) r = ST_FIN;
    if (p.ovf && (cur < ST_OVF)) r = ST_OVF;
    if (p.byte_out && (cur < ST_BYTE)) r = ST_BYTE;
    if (p.flush && (cur < ST_FLUSH)) r = ST_FLUSH;
    return r;
  endfunction

endpackage

FILE: rtl/quoted_field_splitter.sv
// top level of the quoted field splitter
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tdata byte_value, tuser byte_present, tlast string_end
//  m_*      out  m_tvalid/m_tready   tdata out_byte, tuser flags, tlast run_last
//  cfg_*    in   cfg_we              cfg_index register, cfg_wdata value
//
// an item is taken when s_tvalid and s_tready are high; an item that gives results keeps
// the input closed until its last result, one result per cycle from the sequencer into
// the output register while it is not stalled; flushed whitespace is read from the pending
// ram, one entry per cycle; items with no result leave the input open
// synchronous reset clears all control state; the pending ram needs no clearing
// a stalled output holds the sequencer, and with it the input
module quoted_field_splitter #(
  parameter int PENDING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_value
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // string_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic [3:0]  m_tuser,   // out_byte_valid, field_done, field_discard, space_overflow
  output logic        m_tlast,   // run_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);

  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic [8:0]          separator;
  logic [16:0]         max_splits;

  logic                in_quotes;
  logic [7:0]          previous_byte;
  logic                field_started;
  logic [16:0]         splits_left;
  logic                raw_tail_mode;
  logic [CW-1:0]       pending_count;
  logic                string_open;

  qfs_pkg::state_t     state, state_next, stage_nxt;
  qfs_pkg::plan_t      plan, plan_next;
  logic [CW-1:0]       fl_left;
  logic [AW-1:0]       idx, idx_next;

  logic                in_quotes_next;
  logic [7:0]          previous_byte_next;
  logic                field_started_next;
  logic [16:0]         splits_left_next;
  logic                raw_tail_mode_next;
  logic [CW-1:0]       pending_count_next;
  logic                string_open_next;

  logic                accept, active, ld, emit;
  logic                ram_we;
  logic [7:0]          ram_rdata;

  logic [7:0]          res_byte;
  logic [3:0]          res_user;
  logic                res_last;

  assign s_tready = (state == qfs_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign active   = s_tuser || s_tlast;
  assign ld       = !m_tvalid || m_tready;
  assign emit     = ld && (state != qfs_pkg::ST_IDLE);

  // accept path: state update and result plan of one item
  always_comb begin
    logic [16:0]   e_sl;
    logic          e_raw, e_inq, e_fs;
    logic [7:0]    e_prev;
    logic [CW-1:0] e_pc;
    logic          do_feed, do_fin, ws, match;
    e_sl    = string_open ? splits_left : max_splits;
    e_raw   = string_open ? raw_tail_mode : (max_splits == 17'd0);
    e_inq   = string_open && in_quotes;
    e_fs    = string_open && field_started;
    e_prev  = string_open ? previous_byte : 8'd0;
    e_pc    = string_open ? pending_count : '0;
    ws      = qfs_pkg::is_ws(s_tdata);
    match   = (separator == qfs_pkg::WS_SELECT) ? ws : (separator == {1'b0, s_tdata});
    do_feed = 1'b0;
    do_fin  = 1'b0;
    in_quotes_next     = e_inq;
    splits_left_next   = e_sl;
    raw_tail_mode_next = e_raw;
    field_started_next = e_fs;
    pending_count_next = e_pc;
    previous_byte_next = e_prev;
    string_open_next   = 1'b1;
    ram_we    = 1'b0;
    plan_next = '0;
    plan_next.byte_val = s_tdata;
    if (s_tuser) begin
      if (e_raw) begin
        do_feed = 1'b1;
      end else if (e_inq) begin
        do_feed = 1'b1;
        if ((s_tdata == qfs_pkg::QUOTE_BYTE) && (e_prev != qfs_pkg::ESCAPE_BYTE)) begin
          in_quotes_next = 1'b0;
        end
      end else if (s_tdata == qfs_pkg::QUOTE_BYTE) begin
        do_feed = 1'b1;
        in_quotes_next = 1'b1;
      end else if (match) begin
        do_fin = 1'b1;
        if (!e_sl[16] && (e_sl != 17'd0)) begin
          splits_left_next = e_sl - 17'd1;
          if (e_sl == 17'd1) begin
            raw_tail_mode_next = 1'b1;
          end
        end
      end else begin
        do_feed = 1'b1;
      end
      previous_byte_next = s_tdata;
    end
    if (do_feed) begin
      if (ws) begin
        if (e_fs) begin
          if (e_pc < CW'(PENDING_DEPTH)) begin
            ram_we = accept;
            pending_count_next = e_pc + CW'(1);
          end else begin
            plan_next.ovf = 1'b1;
          end
        end
      end else begin
        plan_next.flush    = (e_pc != '0);
        plan_next.byte_out = 1'b1;
        pending_count_next = '0;
        field_started_next = 1'b1;
      end
    end
    if (do_fin) begin
      plan_next.fin = e_fs || (separator != qfs_pkg::WS_SELECT);
      field_started_next = 1'b0;
      pending_count_next = '0;
    end
    if (s_tlast) begin
      if (in_quotes_next) begin
        plan_next.end_out  = 1'b1;
        plan_next.end_disc = 1'b1;
      end else begin
        plan_next.end_out = field_started_next || (separator != qfs_pkg::WS_SELECT);
      end
      in_quotes_next     = 1'b0;
      field_started_next = 1'b0;
      pending_count_next = '0;
      raw_tail_mode_next = 1'b0;
      previous_byte_next = 8'd0;
      string_open_next   = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    stage_nxt  = qfs_pkg::ST_IDLE;
    case (state)
      qfs_pkg::ST_IDLE: begin
        if (accept && active) begin
          state_next = qfs_pkg::stage_after(plan_next, qfs_pkg::ST_IDLE);
        end
      end
      qfs_pkg::ST_FLUSH: begin
        stage_nxt = (fl_left > CW'(1)) ? qfs_pkg::ST_FLUSH :
                    qfs_pkg::stage_after(plan, qfs_pkg::ST_FLUSH);
        if (ld) state_next = stage_nxt;
      end
      default: begin
        stage_nxt = qfs_pkg::stage_after(plan, state);
        if (ld) state_next = stage_nxt;
      end
    endcase
  end

  // result of the current sequencer step
  always_comb begin
    res_byte = 8'd0;
    res_user = 4'b0000;
    res_last = (stage_nxt == qfs_pkg::ST_IDLE);
    case (state)
      qfs_pkg::ST_FLUSH: begin
        res_byte = ram_rdata;
        res_user = 4'b0001;
      end
      qfs_pkg::ST_BYTE: begin
        res_byte = plan.byte_val;
        res_user = 4'b0001;
      end
      qfs_pkg::ST_OVF: res_user = 4'b1000;
      qfs_pkg::ST_FIN: res_user = 4'b0010;
      qfs_pkg::ST_END: res_user = plan.end_disc ? 4'b0100 : 4'b0010;
      default: res_user = 4'b0000;
    endcase
  end

  always_comb begin
    idx_next = idx;
    if (accept) begin
      idx_next = '0;
    end else if (emit && (state == qfs_pkg::ST_FLUSH)) begin
      idx_next = idx + AW'(1);
    end
  end

  qfs_ram #(
    .WIDTH(8),
    .DEPTH(PENDING_DEPTH)
  ) u_pending (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pending_count_next[AW-1:0] - AW'(1)),
    .wdata (s_tdata),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      separator  <= qfs_pkg::WS_SELECT;
      max_splits <= 17'h1FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        qfs_pkg::CFG_SEPARATOR:  separator  <= cfg_wdata[8:0];
        qfs_pkg::CFG_MAX_SPLITS: max_splits <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= qfs_pkg::ST_IDLE;
      in_quotes     <= 1'b0;
      previous_byte <= 8'd0;
      field_started <= 1'b0;
      splits_left   <= 17'd0;
      raw_tail_mode <= 1'b0;
      pending_count <= '0;
      string_open   <= 1'b0;
      fl_left       <= '0;
      idx           <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (accept && active) begin
        in_quotes     <= in_quotes_next;
        previous_byte <= previous_byte_next;
        field_started <= field_started_next;
        splits_left   <= splits_left_next;
        raw_tail_mode <= raw_tail_mode_next;
        pending_count <= pending_count_next;
        string_open   <= string_open_next;
        fl_left       <= plan_next.flush ?
                         (string_open ? pending_count : '0) : '0;
      end else if (emit && (state == qfs_pkg::ST_FLUSH)) begin
        fl_left <= fl_left - CW'(1);
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      plan <= plan_next;
    end
    if (emit) begin
      m_tdata <= res_byte;
      m_tuser <= res_user;
      m_tlast <= res_last;
    end
  end

endmodule

FILE: rtl/qfs_ram.sv
// generic single write port ram with registered read
module qfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/qfs_checker.sv
// port-level checks of the quoted field splitter and their binding
module qfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [3:0] m_tuser,
  input logic       m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // every result is exactly one kind
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tuser))
    else $error("result kind not one-hot");

  // no byte value on a flag-only result
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
    else $error("byte set on flag result");

  // input stays closed while results of the request are still due
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input open before last result");

  // a discard ends the run
  a_disc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast)
    else $error("discard not last result");

endmodule

bind quoted_field_splitter qfs_checker u_qfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: dv/tb_quoted_field_splitter.sv
// self-checking testbench of the quoted field splitter
module tb_quoted_field_splitter;

  localparam int WS_DEPTH = 32;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       done;
    logic       discard;
    logic       overflow;
    logic       last;
  } piece_t;

  // running model of the splitter and the field pieces still owed by the block
  class field_board;
    logic [8:0] sep;
    int         split_limit;
    int         splits_left;
    bit         in_quotes;
    bit         field_started;
    bit         raw_tail;
    bit         string_open;
    logic [7:0] prev_byte;
    logic [7:0] held_ws[$];
    piece_t     expected_q[$];
    piece_t     item_out[$];
    int         errors;

    function new();
      sep = qfs_pkg::WS_SELECT;
      split_limit = -1;
      splits_left = 0;
      in_quotes = 0;
      field_started = 0;
      raw_tail = 0;
      string_open = 0;
      prev_byte = 8'h00;
      errors = 0;
    endfunction

    function bit is_space(logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function void push_piece(logic [7:0] d, bit ok, bit done, bit disc, bit ovf);
      piece_t p;
      p.data = d;
      p.byte_ok = ok;
      p.done = done;
      p.discard = disc;
      p.overflow = ovf;
      p.last = 1'b0;
      item_out.push_back(p);
    endfunction

    // trimming: leading blanks dropped, inner blanks held until a non-blank shows up
    function void take_byte(logic [7:0] c);
      if (is_space(c)) begin
        if (!field_started) return;
        if (held_ws.size() < WS_DEPTH) held_ws.push_back(c);
        else push_piece(8'h00, 0, 0, 0, 1);
        return;
      end
      foreach (held_ws[i]) push_piece(held_ws[i], 1, 0, 0, 0);
      held_ws.delete();
      push_piece(c, 1, 0, 0, 0);
      field_started = 1;
    endfunction

    function void close_field();
      if (field_started || (sep != qfs_pkg::WS_SELECT)) push_piece(8'h00, 0, 1, 0, 0);
      field_started = 0;
      held_ws.delete();
    endfunction

    function void note_request(logic [7:0] c, bit present, bit str_end);
      bit hit;
      if (!present && !str_end) return;
      if (!string_open) begin
        string_open = 1;
        splits_left = split_limit;
        raw_tail = (split_limit == 0);
        in_quotes = 0;
        prev_byte = 8'h00;
        field_started = 0;
        held_ws.delete();
      end
      if (present) begin
        hit = (sep == qfs_pkg::WS_SELECT) ? is_space(c) : (sep == {1'b0, c});
        if (raw_tail) begin
          take_byte(c);
        end else if (in_quotes) begin
          take_byte(c);
          if ((c == qfs_pkg::QUOTE_BYTE) && (prev_byte != qfs_pkg::ESCAPE_BYTE)) in_quotes = 0;
        end else if (c == qfs_pkg::QUOTE_BYTE) begin
          take_byte(c);
          in_quotes = 1;
        end else if (hit) begin
          close_field();
          if (splits_left > 0) begin
            splits_left--;
            if (splits_left == 0) raw_tail = 1;
          end
        end else begin
          take_byte(c);
        end
        prev_byte = c;
      end
      if (str_end) begin
        if (in_quotes) push_piece(8'h00, 0, 0, 1, 0);
        else close_field();
        in_quotes = 0;
        field_started = 0;
        held_ws.delete();
        raw_tail = 0;
        prev_byte = 8'h00;
        string_open = 0;
      end
      if (item_out.size() > 0) item_out[item_out.size() - 1].last = 1'b1;
      foreach (item_out[i]) expected_q.push_back(item_out[i]);
      item_out.delete();
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch expected %0h actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(piece_t got);
      piece_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("out_byte", want.data, got.data);
      compare_field("out_byte_valid", want.byte_ok, got.byte_ok);
      compare_field("field_done", want.done, got.done);
      compare_field("field_discard", want.discard, got.discard);
      compare_field("space_overflow", want.overflow, got.overflow);
      compare_field("run_last", want.last, got.last);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // byte_value
  logic        s_tuser = 1'b0;    // byte_present
  logic        s_tlast = 1'b0;    // string_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // out_byte
  logic [3:0]  m_tuser;           // out_byte_valid, field_done, field_discard, space_overflow
  logic        m_tlast;           // run_last
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = 17'd0;

  field_board board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  quoted_field_splitter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    piece_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_request(s_tdata, s_tuser, s_tlast);
      if (m_tvalid && m_tready) begin
        got.data = m_tdata;
        got.byte_ok = m_tuser[0];
        got.done = m_tuser[1];
        got.discard = m_tuser[2];
        got.overflow = m_tuser[3];
        got.last = m_tlast;
        board.check_result(got);
      end
    end
  end

  task automatic send_item(logic [7:0] b, bit present, bit str_end);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= present;
    s_tlast <= str_end;
    do @(posedge clk); while (!s_tready);
    if (present || str_end) items_sent++;
  endtask

  task automatic send_text(string s, bit with_end);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, with_end && (i == s.len() - 1));
    if ((s.len() == 0) && with_end) send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == qfs_pkg::CFG_SEPARATOR) board.sep = v[8:0];
    else board.split_limit = int'($signed(v));
    @(posedge clk);
  endtask

  function automatic logic [7:0] blank_byte();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'd32 : 8'(9 + k);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'(8'h61 + $urandom_range(0, 25));
      4:          return (board.sep < qfs_pkg::WS_SELECT) ? board.sep[7:0] : blank_byte();
      5:          return blank_byte();
      6:          return qfs_pkg::QUOTE_BYTE;
      7:          return qfs_pkg::ESCAPE_BYTE;
      8:          return 8'($urandom_range(0, 255));
      default:    return 8'h2C;
    endcase
  endfunction

  task automatic send_random_string(bit long_run);
    int n;
    int pos;
    int run_len;
    if (!long_run && ($urandom_range(9) == 0)) begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++)
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 5) == 0);
      return;
    end
    n = $urandom_range(1, 14);
    pos = long_run ? $urandom_range(0, n - 1) : -1;
    for (int k = 0; k < n; k++) begin
      if (k == pos) begin
        run_len = $urandom_range(33, 36);
        send_item(8'h78, 1'b1, 1'b0);
        for (int j = 0; j < run_len; j++) send_item(blank_byte(), 1'b1, 1'b0);
        send_item(8'h79, 1'b1, 1'b0);
      end
      if ($urandom_range(15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, 1'b0);
    end
    if ($urandom_range(2) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else send_item(pick_byte(), 1'b1, 1'b1);
  endtask

  initial begin
    logic [8:0]  sep_list [12];
    logic [16:0] split_list [12];
    int idx;
    int target;
    board = new();
    sep_list = '{9'd256, 9'd44, 9'd0, 9'd34, 9'd255, 9'd257,
                 9'd32, 9'd256, 9'd511, 9'd9, 9'd92, 9'd256};
    split_list = '{17'h1FFFF, 17'd2, 17'd0, 17'h1FFFF, 17'd65535, 17'h1FFFF,
                   17'd1, 17'h10000, 17'd3, 17'h1FFFF, 17'd5, 17'd0};
    send_idle_pct = 35;
    recv_stall_pct = 63;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whitespace mode: empty string, byte extremes, quoted span, escaped quote left open
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_text(" \"b c\" d", 1'b1);
    send_text("\"e\\\" f", 1'b1);
    settle();
    write_reg(qfs_pkg::CFG_SEPARATOR, 17'd44);
    send_text(",", 1'b0);
    // registers changed while a string is open
    settle();
    write_reg(qfs_pkg::CFG_SEPARATOR, {9'd0, qfs_pkg::QUOTE_BYTE});
    write_reg(qfs_pkg::CFG_MAX_SPLITS, 17'd1);
    send_text("a\"b\"", 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    settle();
    write_reg(qfs_pkg::CFG_SEPARATOR, 17'd44);
    send_text("f,g,h", 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 63 : 0;
      recv_stall_pct = (ph == 0) ? 63 : (ph == 1) ? 35 : 0;
      for (int st = 0; st < 4; st++) begin
        idx = ph * 4 + st;
        settle();
        write_reg(qfs_pkg::CFG_SEPARATOR, {8'd0, sep_list[idx]});
        write_reg(qfs_pkg::CFG_MAX_SPLITS, split_list[idx]);
        target = items_sent + 10;
        send_random_string((idx == 0) || ($urandom_range(9) == 0));
        while (items_sent < target) send_random_string($urandom_range(9) == 0);
      end
    end

    settle();
    if (board.errors == 0) $display("tb_quoted_field_splitter passed");
    else $display("tb_quoted_field_splitter failed");
    $finish;
  end

  initial begin
    #400000;
    $display("tb_quoted_field_splitter failed");
    $finish;
  end

endmodule
